FILE: src/atu_pkg.sv
// Shared types, constants and codes for the attention table update block.
// Holds the payload structs, the cell chain structs and the outcome codes.
// No dependencies.
`default_nettype none

package atu_pkg;

	// Attention format: unsigned Q1.15
	localparam int ATTN_BITS = 16;
	localparam logic [ATTN_BITS-1:0] ATTN_ONE = ATTN_BITS'(1) << (ATTN_BITS - 1);
	localparam logic [ATTN_BITS:0] ATTN_ONE_X = {1'b0, ATTN_ONE};

	// Table size
	localparam int DEF_MAX_ENTRIES = 16;
	localparam int CID_BITS = 32;
	localparam int CNT_BITS = 32;
	localparam int STAMP_BITS = 64;
	localparam int EIU_BITS = 5;
	localparam int SLOT_BITS = 4;

	// Configuration registers
	localparam int CFG_DATA_BITS = 16;
	localparam logic REG_MIN_ATTN = 1'b0;
	localparam logic REG_ENTRIES = 1'b1;
	localparam logic [ATTN_BITS-1:0] MIN_ATTN_RESET = 16'd3277;
	localparam logic [EIU_BITS-1:0] ENTRIES_RESET = 5'd16;

	// Result outcome codes
	typedef enum logic [1:0] {
		OUT_MATCH = 2'd0,
		OUT_REUSE = 2'd1,
		OUT_DROP  = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [CID_BITS-1:0]   key_id;
		logic [ATTN_BITS-1:0]  attention_add;
		logic [STAMP_BITS-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           outcome;
		logic [SLOT_BITS-1:0] slot;
		logic [ATTN_BITS-1:0] new_attention;
		logic [CNT_BITS-1:0]  contributors;
	} out_item_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic                  go;
		logic                  any_match;
		logic [CID_BITS-1:0]   key_id;
		logic [ATTN_BITS-1:0]  attention_add;
		logic [STAMP_BITS-1:0] now_ms;
		logic [ATTN_BITS-1:0]  min_attention;
		logic [EIU_BITS-1:0]   entries_in_use;
	} atu_bcast_t;

	// Priority flags handed from one cell to the next
	typedef struct packed {
		logic match_seen;
		logic low_seen;
	} atu_chain_t;

	// Per-cell answer to the controller
	typedef struct packed {
		logic                 sel;
		logic [ATTN_BITS-1:0] new_attention;
		logic [CNT_BITS-1:0]  new_contrib;
	} atu_cell_out_t;

endpackage

`default_nettype wire

FILE: src/atu_cell.sv
// One table entry of the attention table: identifier, attention, count, stamp.
// Checks the broadcast item, hands priority flags to the next cell, updates itself.
// Depends on atu_pkg.
`default_nettype none

module atu_cell #(
	parameter int Index = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  atu_pkg::atu_bcast_t    bcast,
	input  atu_pkg::atu_chain_t    chain_in,
	output atu_pkg::atu_chain_t    chain_out,
	output atu_pkg::atu_cell_out_t cout
);
	import atu_pkg::*;

	logic [CID_BITS-1:0]   concept_q;
	logic [ATTN_BITS-1:0]  attn_q;
	logic [CNT_BITS-1:0]   contrib_q;
	logic [STAMP_BITS-1:0] stamp_q;

	logic                 active;
	logic                 is_match;
	logic                 is_low;
	logic                 sel;
	logic [ATTN_BITS:0]   sum;
	logic [ATTN_BITS-1:0] sat;

	// Qualify this entry against the searched range and the item
	assign active   = int'(bcast.entries_in_use) > Index;
	assign is_match = active && (concept_q == bcast.key_id);
	assign is_low   = active && (attn_q < bcast.min_attention);

	// Pass priority flags down the chain
	assign chain_out.match_seen = chain_in.match_seen | is_match;
	assign chain_out.low_seen   = chain_in.low_seen | is_low;

	// First match wins; without any match, first low entry wins
	assign sel = bcast.go && (bcast.any_match ? (is_match && !chain_in.match_seen)
	                                          : (is_low && !chain_in.low_seen));

	// Saturating add at 1.0
	assign sum = {1'b0, attn_q} + {1'b0, bcast.attention_add};
	assign sat = (sum > ATTN_ONE_X) ? ATTN_ONE : sum[ATTN_BITS-1:0];

	assign cout.sel           = sel;
	assign cout.new_attention = sat;
	assign cout.new_contrib   = contrib_q + CNT_BITS'(1);

	// Update the entry when chosen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			concept_q <= '0;
			attn_q    <= '0;
			contrib_q <= '0;
			stamp_q   <= '0;
		end else if (sel) begin
			concept_q <= bcast.key_id;
			attn_q    <= sat;
			contrib_q <= contrib_q + CNT_BITS'(1);
			stamp_q   <= bcast.now_ms;
		end
	end

endmodule

`default_nettype wire

FILE: src/attention_table_update.sv
// Top level of the attention table update block.
// Holds configuration, the item register, the controller and the row of cells.
// Depends on atu_pkg and atu_cell.
//
// Usage:
//   Input channel: drive item and raise start; the transfer happens at a rising
//   edge with start high and busy low. busy is high for the one search cycle
//   that follows each transfer.
//   Result channel: done pulses for one cycle with result valid; the receiver
//   cannot stall it and must take it in that cycle.
//   Configuration: cfg_we with cfg_index and cfg_wdata writes a register at the
//   edge (index 0 min_attention, index 1 entries_in_use). The user must write
//   only while idle; the block itself does not enforce it.
// Timing:
//   Each item takes the transfer and a search/update step in which all cells
//   compare in parallel and the chosen cell rewrites itself. done rises the
//   cycle after the search, when a new item may already be transferred; by the
//   read-modify-write of the cell row, no item is taken while one is searched.
// Reset:
//   arst_n clears every entry to zero and restores register defaults
//   (min_attention 3277, entries_in_use 16). No clearing pass is needed.
`default_nettype none

module attention_table_update #(
	parameter int MaxEntries = atu_pkg::DEF_MAX_ENTRIES
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	output logic                               busy,
	input  atu_pkg::in_item_t                  item,
	output logic                               done,
	output atu_pkg::out_item_t                 result,
	input  wire                                cfg_we,
	input  wire                                cfg_index,
	input  wire [atu_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
	import atu_pkg::*;

	localparam int IdxBits = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_SEARCH = 2'b10
	} state_t;

	state_t                 state_q;
	in_item_t               item_q;
	logic [ATTN_BITS-1:0]   min_attn_q;
	logic [EIU_BITS-1:0]    entries_q;
	logic [STAMP_BITS-1:0]  table_stamp_q;
	logic                   done_q;
	out_item_t              result_q;

	atu_bcast_t             bcast;
	atu_chain_t             chain [MaxEntries+1];
	atu_cell_out_t          couts [MaxEntries];
	logic [MaxEntries-1:0]  sel_vec;
	logic                   any_sel;
	logic [IdxBits-1:0]     sel_idx;
	logic [ATTN_BITS-1:0]   sel_attn;
	logic [CNT_BITS-1:0]    sel_contrib;
	logic                   accept;

	assign busy   = (state_q == ST_SEARCH);
	assign accept = start && !busy;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_attn_q <= MIN_ATTN_RESET;
			entries_q  <= ENTRIES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_ATTN: min_attn_q <= cfg_wdata[ATTN_BITS-1:0];
				REG_ENTRIES:  entries_q  <= cfg_wdata[EIU_BITS-1:0];
				default:      ;
			endcase
		end
	end

	// Controller: idle, then a search state after each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:   if (accept) state_q <= ST_SEARCH;
				ST_SEARCH: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the transferred item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	// Broadcast to the cell row
	assign bcast.go             = busy;
	assign bcast.any_match      = chain[MaxEntries].match_seen;
	assign bcast.key_id         = item_q.key_id;
	assign bcast.attention_add  = item_q.attention_add;
	assign bcast.now_ms         = item_q.now_ms;
	assign bcast.min_attention  = min_attn_q;
	assign bcast.entries_in_use = entries_q;

	assign chain[0] = '0;

	for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
		atu_cell #(
			.Index(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bcast    (bcast),
			.chain_in (chain[g]),
			.chain_out(chain[g+1]),
			.cout     (couts[g])
		);
		assign sel_vec[g] = couts[g].sel;
	end

	// Gather the chosen cell's values (at most one cell is chosen)
	always_comb begin
		sel_idx     = '0;
		sel_attn    = '0;
		sel_contrib = '0;
		for (int i = 0; i < MaxEntries; i++) begin
			if (sel_vec[i]) begin
				sel_idx     = sel_idx | IdxBits'(i);
				sel_attn    = sel_attn | couts[i].new_attention;
				sel_contrib = sel_contrib | couts[i].new_contrib;
			end
		end
	end

	assign any_sel = |sel_vec;

	// Register the result and the table stamp at the end of the search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q        <= 1'b0;
			table_stamp_q <= '0;
		end else begin
			done_q <= busy;
			if (busy) begin
				table_stamp_q <= item_q.now_ms;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			if (!any_sel) begin
				result_q <= '{outcome: OUT_DROP, default: '0};
			end else begin
				result_q.outcome       <= bcast.any_match ? OUT_MATCH : OUT_REUSE;
				result_q.slot          <= SLOT_BITS'({{SLOT_BITS{1'b0}}, sel_idx});
				result_q.new_attention <= sel_attn;
				result_q.contributors  <= sel_contrib;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	// The search state is always left at the next edge
	a_search_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("search cycle did not end");

	// A result follows each search cycle and nothing else
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result strobe without search");

	// At most one cell is chosen
	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_vec)) else $error("more than one cell chosen");

	// A dropped result carries zero fields
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.outcome == OUT_DROP) |->
		(result.slot == '0 && result.new_attention == '0 && result.contributors == '0))
		else $error("dropped result has nonzero fields");

	// Attention never exceeds 1.0
	a_attn_sat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.new_attention <= ATTN_ONE)) else $error("attention above 1.0");
`endif

endmodule

`default_nettype wire

FILE: tb/attention_table_update_tb.sv
// Self-checking testbench for attention_table_update: directed and random updates
// checked against a table predictor kept in the scoreboard class.
// Depends on atu_pkg and the attention_table_update RTL.
`default_nettype none

module attention_table_update_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import atu_pkg::*;

	localparam int TABLE_DEPTH = DEF_MAX_ENTRIES;
	localparam int CYCLE_LIMIT = 200000;
	localparam int REPORT_MAX = 10;
	localparam int POOL_SIZE = 20;

	// Table predictor and store of expected update results
	class table_scoreboard;
		logic [CID_BITS-1:0]   ids[TABLE_DEPTH];
		logic [ATTN_BITS-1:0]  attn[TABLE_DEPTH];
		logic [CNT_BITS-1:0]   contrib[TABLE_DEPTH];
		logic [STAMP_BITS-1:0] stamp[TABLE_DEPTH];
		logic [STAMP_BITS-1:0] last_stamp;
		logic [ATTN_BITS-1:0]  min_attn;
		logic [EIU_BITS-1:0]   entries;
		out_item_t             expected_q[$];
		int                    n_fail;
		int                    n_noted;
		int                    n_checked;
		int                    n_outcome[3];

		function new();
			foreach (ids[i]) begin
				ids[i] = '0;
				attn[i] = '0;
				contrib[i] = '0;
				stamp[i] = '0;
			end
			last_stamp = '0;
			min_attn = MIN_ATTN_RESET;
			entries = ENTRIES_RESET;
			n_fail = 0;
			n_noted = 0;
			n_checked = 0;
			n_outcome = '{0, 0, 0};
		endfunction

		function void write_reg(logic idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx == REG_MIN_ATTN) begin
				min_attn = data[ATTN_BITS-1:0];
			end else begin
				entries = data[EIU_BITS-1:0];
			end
		endfunction

		function void flag(string msg);
			if (n_fail < REPORT_MAX) begin
				$display("ERROR @%0t: %s", $realtime, msg);
			end
			n_fail++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Search the table, update the chosen entry and queue the expected result
		function void note_input(in_item_t it);
			int           lim;
			int           slot;
			int           low_slot;
			bit           matched;
			bit           have_low;
			logic [ATTN_BITS:0] sum;
			out_item_t    e;
			lim = (entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries);
			matched = 1'b0;
			have_low = 1'b0;
			slot = 0;
			low_slot = 0;
			for (int i = 0; i < lim; i++) begin
				if (ids[i] == it.key_id) begin
					matched = 1'b1;
					slot = i;
					break;
				end
				if (!have_low && attn[i] < min_attn) begin
					have_low = 1'b1;
					low_slot = i;
				end
			end
			last_stamp = it.now_ms;
			n_noted++;
			if (!matched && !have_low) begin
				e.outcome = OUT_DROP;
				e.slot = '0;
				e.new_attention = '0;
				e.contributors = '0;
			end else begin
				if (!matched) begin
					slot = low_slot;
				end
				sum = {1'b0, attn[slot]} + {1'b0, it.attention_add};
				if (sum > ATTN_ONE_X) begin
					sum = ATTN_ONE_X;
				end
				ids[slot] = it.key_id;
				attn[slot] = sum[ATTN_BITS-1:0];
				contrib[slot] = contrib[slot] + 1;
				stamp[slot] = it.now_ms;
				e.outcome = matched ? OUT_MATCH : OUT_REUSE;
				e.slot = SLOT_BITS'(slot);
				e.new_attention = attn[slot];
				e.contributors = contrib[slot];
			end
			expected_q.push_back(e);
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_result(out_item_t got);
			out_item_t e;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected result outcome=%0d slot=%0d attn=%0d contrib=%0d",
					got.outcome, got.slot, got.new_attention, got.contributors));
				return;
			end
			e = expected_q.pop_front();
			n_checked++;
			if (e.outcome < 3) begin
				n_outcome[e.outcome]++;
			end
			if (got.outcome !== e.outcome || got.slot !== e.slot ||
				got.new_attention !== e.new_attention || got.contributors !== e.contributors) begin
				flag($sformatf({"result %0d: exp outcome=%0d slot=%0d attn=%0d contrib=%0d,",
					" got outcome=%0d slot=%0d attn=%0d contrib=%0d"}, n_checked,
					e.outcome, e.slot, e.new_attention, e.contributors,
					got.outcome, got.slot, got.new_attention, got.contributors));
			end
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	in_item_t                 item;
	logic                     done;
	out_item_t                result;
	logic                     cfg_we;
	logic                     cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	table_scoreboard          sb;
	int                       cycles;
	logic [CID_BITS-1:0]      id_pool[POOL_SIZE];

	attention_table_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Bound the run
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(result);
		end
	end

	// Transfer one update after an optional idle gap
	task automatic send_update(in_item_t it, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_input(it);
	endtask

	// Hold the sender until every expected result has come back
	task automatic drain_results();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write one register while the block is idle
	task automatic write_config(logic idx, logic [CFG_DATA_BITS-1:0] data);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
	endtask

	function automatic in_item_t make_item(logic [CID_BITS-1:0] cid,
		logic [ATTN_BITS-1:0] add, logic [STAMP_BITS-1:0] now);
		in_item_t it;
		it.key_id = cid;
		it.attention_add = add;
		it.now_ms = now;
		return it;
	endfunction

	// Mostly pooled concepts so entries get hit again; increments of mixed size
	function automatic in_item_t rand_item();
		logic [CID_BITS-1:0]  cid;
		logic [ATTN_BITS-1:0] add;
		int                   pick;
		cid = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE-1)] : $urandom;
		pick = $urandom_range(99);
		if (pick < 10) begin
			add = '0;
		end else if (pick < 55) begin
			add = ATTN_BITS'($urandom_range(2000));
		end else if (pick < 80) begin
			add = ATTN_BITS'($urandom_range(32768));
		end else begin
			add = ATTN_BITS'($urandom);
		end
		return make_item(cid, add, {$urandom, $urandom});
	endfunction

	initial begin
		logic [CFG_DATA_BITS-1:0] min_list[10];
		int                       entry_list[10];
		int                       idle_pct;
		int                       gap;

		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN_ATTN;
		cfg_wdata = '0;
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			id_pool[i] = $urandom;
		end
		min_list = '{16'd3277, 16'd0, 16'hFFFF, 16'h8000, 16'($urandom),
			16'd3277, 16'h7FFF, 16'($urandom), 16'd1, 16'd3277};
		entry_list = '{16, 1, 31, 2, 8, 17, 16, 3, 12, 16};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: cleared table, extremes of every field, saturation
		send_update(make_item('0, '0, '0), 0);
		send_update(make_item('1, '1, '1), 0);
		send_update(make_item(32'h1234_5678, 16'h8000, 64'd1), 0);
		send_update(make_item(32'h1234_5678, 16'd1, 64'd2), 1);
		send_update(make_item('0, 16'd100, 64'd3), 0);

		// Two searched entries, both saturated: a new concept is dropped
		write_config(REG_ENTRIES, 16'hFFE2);
		send_update(make_item(32'hA5A5_0001, 16'd5, 64'd4), 0);
		send_update(make_item(32'h1234_5678, 16'd5, 64'd5), 0);

		// Empty range drops everything, even concept 0
		write_config(REG_ENTRIES, 16'd0);
		send_update(make_item('0, 16'd7, 64'd6), 0);
		send_update(make_item(32'hA5A5_0002, 16'd7, 64'd7), 2);

		// Oversized range is clipped to the table size
		write_config(REG_ENTRIES, 16'd31);
		send_update(make_item('0, 16'd9, 64'd8), 0);
		send_update(make_item(32'hA5A5_0003, 16'd9, 64'd9), 0);

		// Zero threshold: nothing reusable
		write_config(REG_MIN_ATTN, 16'd0);
		send_update(make_item(32'hA5A5_0004, 16'd9, 64'd10), 0);

		// Threshold above one: every entry reusable, oversized increment
		write_config(REG_MIN_ATTN, 16'hFFFF);
		send_update(make_item(32'hA5A5_0005, 16'h8001, 64'd11), 0);
		send_update(make_item(32'hA5A5_0006, 16'hFFFF, 64'd12), 0);

		// Random phases with varied settings and sender idling
		for (int ph = 0; ph < 10; ph++) begin
			write_config(REG_MIN_ATTN, min_list[ph]);
			write_config(REG_ENTRIES, {11'($urandom), 5'(entry_list[ph])});
			idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 65 : 10;
			for (int k = 0; k < 150; k++) begin
				if (k == 75) begin
					drain_results();
				end
				gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
				send_update(rand_item(), gap);
			end
		end

		// Let the tail settle
		drain_results();
		repeat (8) @(posedge clk);
		while (sb.pending() != 0) begin
			void'(sb.expected_q.pop_front());
			sb.flag("expected result never arrived");
		end

		$display("Sent %0d updates over 10 random settings, checked %0d results",
			sb.n_noted, sb.n_checked);
		$display("Outcomes: %0d matched, %0d reused, %0d dropped; %0d errors",
			sb.n_outcome[OUT_MATCH], sb.n_outcome[OUT_REUSE], sb.n_outcome[OUT_DROP],
			sb.n_fail);
		if (sb.n_fail == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
src/atu_pkg.sv
src/atu_cell.sv
src/attention_table_update.sv
tb/attention_table_update_tb.sv
